// ===== sv/sfs_pkg.sv =====
// Shared types and constants for the sample frame serializer.
package sfs_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned TagW     = 16;
  localparam int unsigned FrameLen = 17;
  localparam int unsigned CntW     = $clog2(FrameLen);

  localparam logic [ByteW-1:0]  HdrFirst  = 8'hAA;
  localparam logic [ByteW-1:0]  HdrSecond = 8'h55;
  localparam logic [CntW-1:0]   LastIdx   = CntW'(FrameLen - 1);

  // Byte positions inside a frame.
  localparam int unsigned PosWordX = 2;
  localparam int unsigned PosWordY = 6;
  localparam int unsigned PosWordZ = 10;
  localparam int unsigned PosTagHi = 14;
  localparam int unsigned PosTagLo = 15;
  localparam int unsigned PosSum   = 16;

  typedef logic [WordW-1:0] word_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [TagW-1:0]  tag_t;

  // Element 0 is sent first.
  typedef logic [FrameLen-1:0][ByteW-1:0] frame_t;

  typedef struct packed {
    logic valid;
  } hs_t;

endpackage

// ===== sv/sfs_if.sv =====
// Channel interfaces: sample input and byte output.
interface sfs_in_if;
  logic              valid;
  logic              ready;
  sfs_pkg::word_t    word_x;
  sfs_pkg::word_t    word_y;
  sfs_pkg::word_t    word_z;

  modport source (output valid, output word_x, output word_y, output word_z, input ready);
  modport sink   (input valid, input word_x, input word_y, input word_z, output ready);
endinterface

interface sfs_out_if;
  logic              valid;
  logic              ready;
  sfs_pkg::byte_t    out_byte;
  logic              frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

// ===== sv/sfs_frame_build.sv =====
// Input register, frame tag and frame assembly with checksum.
module sfs_frame_build (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfs_pkg::word_t    in_word_x,
  input  sfs_pkg::word_t    in_word_y,
  input  sfs_pkg::word_t    in_word_z,
  output sfs_pkg::hs_t      frm_hs_o,
  input  logic              frm_ready,
  output sfs_pkg::frame_t   frame_o
);

  logic           valid_r;
  sfs_pkg::word_t wx_r, wy_r, wz_r;
  sfs_pkg::tag_t  tag_r;
  sfs_pkg::tag_t  tag_nxt;
  logic           take;

  sfs_pkg::byte_t p [7];
  sfs_pkg::byte_t q0, q1, q2, q3, r0, r1, sum;

  assign take     = valid_r && frm_ready;
  assign in_ready = !valid_r || frm_ready;
  assign tag_nxt  = tag_r + sfs_pkg::tag_t'(1);

  assign frm_hs_o.valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tag_r   <= '0;
    end else begin
      if (in_valid && in_ready) begin
        valid_r <= 1'b1;
      end else if (take) begin
        valid_r <= 1'b0;
      end
      // advance the tag as each frame leaves for the serializer
      if (take) begin
        tag_r <= tag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      wx_r <= in_word_x;
      wy_r <= in_word_y;
      wz_r <= in_word_z;
    end
  end

  always_comb begin
    frame_o = '0;
    frame_o[0] = sfs_pkg::HdrFirst;
    frame_o[1] = sfs_pkg::HdrSecond;
    for (int b = 0; b < 4; b++) begin
      frame_o[sfs_pkg::PosWordX + b] = wx_r[b*sfs_pkg::ByteW +: sfs_pkg::ByteW];
      frame_o[sfs_pkg::PosWordY + b] = wy_r[b*sfs_pkg::ByteW +: sfs_pkg::ByteW];
      frame_o[sfs_pkg::PosWordZ + b] = wz_r[b*sfs_pkg::ByteW +: sfs_pkg::ByteW];
    end
    frame_o[sfs_pkg::PosTagHi] = tag_nxt[sfs_pkg::TagW-1 -: sfs_pkg::ByteW];
    frame_o[sfs_pkg::PosTagLo] = tag_nxt[sfs_pkg::ByteW-1:0];

    // checksum over bytes 2..15 as an adder tree, wrapping at 8 bits
    for (int i = 0; i < 7; i++) begin
      p[i] = frame_o[2 + 2*i] + frame_o[3 + 2*i];
    end
    q0  = p[0] + p[1];
    q1  = p[2] + p[3];
    q2  = p[4] + p[5];
    q3  = p[6];
    r0  = q0 + q1;
    r1  = q2 + q3;
    sum = r0 + r1;
    frame_o[sfs_pkg::PosSum] = sum;
  end

endmodule

// ===== sv/sfs_byte_ser.sv =====
// Frame shift register that sends one byte per transfer.
module sfs_byte_ser (
  input  logic              clk,
  input  logic              rst_n,
  input  sfs_pkg::hs_t      frm_hs_i,
  output logic              frm_ready,
  input  sfs_pkg::frame_t   frame_i,
  output logic              out_valid,
  input  logic              out_ready,
  output sfs_pkg::byte_t    out_byte,
  output logic              out_frame_end
);

  logic                    valid_r;
  logic [sfs_pkg::CntW-1:0] cnt_r;
  sfs_pkg::frame_t         frame_r;
  logic                    last;
  logic                    fire;
  logic                    load;

  assign last      = (cnt_r == sfs_pkg::LastIdx);
  assign fire      = valid_r && out_ready;
  assign frm_ready = !valid_r || (fire && last);
  assign load      = frm_hs_i.valid && frm_ready;

  assign out_valid     = valid_r;
  assign out_byte      = frame_r[0];
  assign out_frame_end = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      cnt_r   <= '0;
    end else if (fire) begin
      // drop out after the checksum byte unless a new frame loads
      valid_r <= !last;
      cnt_r   <= last ? '0 : cnt_r + sfs_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= frame_i;
    end else if (fire) begin
      frame_r <= frame_r >> sfs_pkg::ByteW;
    end
  end

endmodule

// ===== sv/sample_frame_serializer_top.sv =====
// Top level of the sample frame serializer.
//
// in_ch carries one sample per transfer: word_x, word_y, word_z. out_ch
// carries the frame one byte per transfer: 0xAA, 0x55, the twelve word
// bytes (each word low byte first), tag high byte, tag low byte, then the
// checksum (8-bit sum of the word and tag bytes) with frame_end high.
// The tag steps by one before each frame, so the first frame carries 1.
//
// When the block is empty, a sample passes through the input register and then
// the output shift register before the first byte of its frame appears. Output
// runs at one byte per cycle while the receiver does not stall, set by the single
// byte lane of the output shift register. One sample waits in the input register
// while a frame is shifted out, and it loads in the cycle the checksum byte is
// taken, so frames run without gaps.
//
// Reset clears the tag to zero and empties both stages. When the receiver
// stalls, the current byte holds on out_ch, and in_ch stops accepting once
// the input register is full.
module sample_frame_serializer_top (
  input  logic       clk,
  input  logic       rst_n,
  sfs_in_if.sink     in_ch,
  sfs_out_if.source  out_ch
);

  sfs_pkg::hs_t    frm_hs;
  logic            frm_ready;
  sfs_pkg::frame_t frame;

  sfs_frame_build u_build (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_word_x (in_ch.word_x),
    .in_word_y (in_ch.word_y),
    .in_word_z (in_ch.word_z),
    .frm_hs_o  (frm_hs),
    .frm_ready (frm_ready),
    .frame_o   (frame)
  );

  sfs_byte_ser u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .frm_hs_i      (frm_hs),
    .frm_ready     (frm_ready),
    .frame_i       (frame),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_byte      (out_ch.out_byte),
    .out_frame_end (out_ch.frame_end)
  );

endmodule

// ===== verif/sample_frame_serializer_top_tb.sv =====
// Self-checking testbench for the sample frame serializer: frame bytes, tag and checksum.
module sample_frame_serializer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 40;

  typedef struct {
    sfs_pkg::byte_t value;
    logic           last;
  } frame_byte_t;

  logic clk;
  logic rst_n;

  sfs_in_if  in_ch();
  sfs_out_if out_ch();

  sample_frame_serializer_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_byte_t    pending_bytes[$];
  sfs_pkg::tag_t  tag_model;
  int unsigned    mismatch_count;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  logic           hold_request;
  int unsigned    hold_left;
  int unsigned    cycle_count;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  // Step the tag, then queue the 17 bytes of the frame for this sample.
  task automatic predict_frame(input sfs_pkg::word_t x, input sfs_pkg::word_t y,
                               input sfs_pkg::word_t z);
    sfs_pkg::word_t words[3];
    sfs_pkg::byte_t sum;
    sfs_pkg::byte_t b;
    frame_byte_t    fb;
    words[0] = x;
    words[1] = y;
    words[2] = z;
    sum = '0;
    tag_model = tag_model + 1'b1;
    fb.last = 1'b0;
    fb.value = sfs_pkg::HdrFirst;
    pending_bytes.push_back(fb);
    fb.value = sfs_pkg::HdrSecond;
    pending_bytes.push_back(fb);
    for (int w = 0; w < 3; w++) begin
      for (int k = 0; k < 4; k++) begin
        b = words[w][8*k +: 8];
        sum = sum + b;
        fb.value = b;
        pending_bytes.push_back(fb);
      end
    end
    fb.value = tag_model[15:8];
    sum = sum + fb.value;
    pending_bytes.push_back(fb);
    fb.value = tag_model[7:0];
    sum = sum + fb.value;
    pending_bytes.push_back(fb);
    fb.value = sum;
    fb.last = 1'b1;
    pending_bytes.push_back(fb);
  endtask

  // Hold valid high across back-to-back transfers; drop it only while idling.
  task automatic send_sample(input sfs_pkg::word_t x, input sfs_pkg::word_t y,
                             input sfs_pkg::word_t z);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.word_x <= x;
    in_ch.word_y <= y;
    in_ch.word_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    predict_frame(x, y, z);
  endtask

  function automatic sfs_pkg::word_t pick_word();
    int unsigned bit_pos;
    bit_pos = $urandom_range(0, sfs_pkg::WordW - 1);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return sfs_pkg::word_t'(1) << bit_pos;
      3: return ~(sfs_pkg::word_t'(1) << bit_pos);
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random backpressure, or a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare every byte transfer with the oldest expected byte.
  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected byte", out_ch.out_byte, 0);
      end else begin
        want = pending_bytes.pop_front();
        if (out_ch.out_byte !== want.value)
          report_mismatch("out_byte", out_ch.out_byte, want.value);
        if (out_ch.frame_end !== want.last)
          report_mismatch("frame_end", out_ch.frame_end, want.last);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL sample_frame_serializer_top");
    $finish;
  end

  task automatic test_directed();
    send_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98);
    send_sample(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_sample(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF);
    send_sample(32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000);
    send_sample(32'hFF00_0000, 32'hFFFF_FFFE, 32'hDEAD_BEEF);
    send_sample(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  task automatic test_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_sample(pick_word(), pick_word(), pick_word());
  endtask

  // Stall the receiver while samples keep coming, so the input side backs up.
  task automatic test_backpressure();
    hold_request = 1'b1;
    test_random(12);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.word_x   = '0;
    in_ch.word_y   = '0;
    in_ch.word_z   = '0;
    out_ch.ready   = 1'b0;
    tag_model      = '0;
    mismatch_count = 0;
    hold_request   = 1'b0;
    hold_left      = 0;
    send_idle_pct  = 37;
    recv_idle_pct  = 48;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(130);
    test_backpressure();

    send_idle_pct = 48;
    recv_idle_pct = 37;
    test_random(130);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(130);

    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS sample_frame_serializer_top");
    end else begin
      $display("FAIL sample_frame_serializer_top");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sfs_pkg.sv
sv/sfs_if.sv
sv/sfs_frame_build.sv
sv/sfs_byte_ser.sv
sv/sample_frame_serializer_top.sv
verif/sample_frame_serializer_top_tb.sv
